@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL. Simulation gets the checks; synthesis gets nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ETSI_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

`define ETSI_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define ETSI_ASSERT(lbl, clk, rst, prop)
`define ETSI_ASSERT_IMPL(lbl, clk, rst, ante, cons)

`endif

`endif

@@ sv/etsi_pkg.sv @@
package etsi_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int NODE_BITS   = 16;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int FUNC_W  = 3;
  localparam int NODE_W  = 16;
  localparam int LEN_W   = 32;
  localparam int INDEX_W = 12;
  localparam int COUNT_W = 13;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD    = 3'd0,
    FN_QUERY  = 3'd1,
    FN_DELETE = 3'd2,
    FN_APPEND = 3'd3,
    FN_CLEAR  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

  // One input beat, func in the lowest bits.
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [LEN_W-1:0]   edge_len;
    logic [NODE_W-1:0]  node_b;
    logic [NODE_W-1:0]  node_a;
    logic [FUNC_W-1:0]  func;
  } item_t;

  // One result beat, accepted in the lowest bit.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               full_res;
    logic               found;
    logic               accepted;
  } res_t;

  // One stored edge.
  typedef struct packed {
    logic [LEN_W-1:0]     len;
    logic [NODE_BITS-1:0] nb;
    logic [NODE_BITS-1:0] na;
  } entry_t;

  localparam int ENTRY_W    = $bits(entry_t);
  localparam int IN_TDATA_W = (($bits(item_t) + 7) / 8) * 8;
  localparam int OUT_TDATA_W = (($bits(res_t) + 7) / 8) * 8;

endpackage

@@ sv/edge_table_shortest_insert_top.sv @@
// Edge table with shortest-edge insertion. Each input beat carries one operation (add if
// shortest, exists query, delete by index, append, clear) and produces exactly one result
// beat with the accepted, found and full flags and the fill count after the operation.
// The table lives in one synchronous RAM with one read and one write port. Add walks the
// table one entry per cycle from its start index, query from entry zero, and delete moves
// every entry above the index down one place per cycle. Append, clear, a self-loop query,
// a delete past the fill count, an add whose start index is at or past the fill count and
// unused codes go straight to the result without reading the RAM. One operation runs at a
// time; the next beat is taken as soon as the previous result sits in the output register,
// so a stalled output holds off the next beat. No pass runs after reset: the table is empty
// at once and entries past the fill count are never read.
module edge_table_shortest_insert_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // func[2:0], node_a[18:3], node_b[34:19], edge_len[66:35], index[78:67], zero pad
  input  logic [etsi_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // accepted[0], found[1], full_res[2], count[15:3]
  output logic [etsi_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  etsi_pkg::item_t item;
  etsi_pkg::res_t  res;
  etsi_pkg::res_t  out_res;
  logic            res_valid;
  logic            res_ready;

  assign item      = etsi_pkg::item_t'(s_axis_tdata[$bits(etsi_pkg::item_t)-1:0]);
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  etsi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = etsi_pkg::OUT_TDATA_W'(out_res);

endmodule

@@ sv/etsi_ram.sv @@
module etsi_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/etsi_ctrl.sv @@
`include "assert_macros.svh"

module etsi_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  etsi_pkg::item_t in_item,
  output logic          res_valid,
  input  logic          res_ready,
  output etsi_pkg::res_t  res
);

  etsi_pkg::state_t state, state_next;
  logic [etsi_pkg::FUNC_W-1:0]    op, op_next;
  logic [etsi_pkg::NODE_BITS-1:0] na, na_next, nb, nb_next;
  logic [etsi_pkg::LEN_W-1:0]     len, len_next;
  logic [etsi_pkg::CNT_W-1:0]     count, count_next;
  logic [etsi_pkg::CNT_W-1:0]     rd_ptr, rd_ptr_next;
  logic                           rd_vld, rd_vld_next;
  logic [etsi_pkg::IDX_W-1:0]     rd_addr, rd_addr_next;
  logic                           first_seen, first_seen_next;
  logic                           acc, acc_next, found, found_next, full, full_next;

  logic                           wr_en;
  logic [etsi_pkg::IDX_W-1:0]     wr_addr;
  etsi_pkg::entry_t               wr_data;
  etsi_pkg::entry_t               rd_data;
  logic                           issue;
  logic                           tbl_full;
  logic                           hit_pair;
  logic [etsi_pkg::NODE_BITS-1:0] in_a, in_b;
  logic [etsi_pkg::COUNT_W-1:0]   idx_ext, cnt_ext;

  etsi_ram #(
    .DEPTH (etsi_pkg::TABLE_DEPTH),
    .WIDTH (etsi_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_ptr[etsi_pkg::IDX_W-1:0]),
    .rdata (rd_data)
  );

  assign in_a     = in_item.node_a[etsi_pkg::NODE_BITS-1:0];
  assign in_b     = in_item.node_b[etsi_pkg::NODE_BITS-1:0];
  assign idx_ext  = etsi_pkg::COUNT_W'(in_item.index);
  assign cnt_ext  = etsi_pkg::COUNT_W'(count);
  assign issue    = rd_ptr < count;
  assign tbl_full = count == etsi_pkg::FULL_CNT;
  assign hit_pair = (rd_data.na == na && rd_data.nb == nb) ||
                    (rd_data.na == nb && rd_data.nb == na);

  assign in_ready  = state == etsi_pkg::ST_IDLE;
  assign res_valid = state == etsi_pkg::ST_DONE;
  assign res.accepted = acc;
  assign res.found    = found;
  assign res.full_res = full;
  assign res.count    = cnt_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= etsi_pkg::ST_IDLE;
      count  <= '0;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rd_vld <= rd_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    na         <= na_next;
    nb         <= nb_next;
    len        <= len_next;
    rd_ptr     <= rd_ptr_next;
    rd_addr    <= rd_addr_next;
    first_seen <= first_seen_next;
    acc        <= acc_next;
    found      <= found_next;
    full       <= full_next;
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    na_next         = na;
    nb_next         = nb;
    len_next        = len;
    count_next      = count;
    rd_ptr_next     = rd_ptr;
    rd_vld_next     = 1'b0;
    rd_addr_next    = rd_addr;
    first_seen_next = first_seen;
    acc_next        = acc;
    found_next      = found;
    full_next       = full;
    wr_en           = 1'b0;
    wr_addr         = count[etsi_pkg::IDX_W-1:0];
    wr_data         = '{len: len, nb: nb, na: na};

    unique case (state)
      etsi_pkg::ST_IDLE: begin
        wr_data = '{len: in_item.edge_len, nb: in_b, na: in_a};
        if (in_valid) begin
          op_next         = in_item.func;
          na_next         = in_a;
          nb_next         = in_b;
          len_next        = in_item.edge_len;
          first_seen_next = 1'b0;
          acc_next        = 1'b0;
          found_next      = 1'b0;
          full_next       = 1'b0;
          state_next      = etsi_pkg::ST_DONE;
          unique case (in_item.func) inside
            etsi_pkg::FN_ADD, etsi_pkg::FN_APPEND: begin
              // A start index at or past the fill level scans nothing and appends unless the table is full.
              if (in_item.func == etsi_pkg::FN_ADD && idx_ext < cnt_ext) begin
                rd_ptr_next = etsi_pkg::CNT_W'(in_item.index);
                state_next  = etsi_pkg::ST_SCAN;
              end else if (tbl_full) begin
                full_next = 1'b1;
              end else begin
                wr_en      = 1'b1;
                count_next = count + 1'b1;
                acc_next   = 1'b1;
              end
            end
            etsi_pkg::FN_QUERY: begin
              if (in_a == in_b) begin
                found_next = 1'b1;
              end else begin
                rd_ptr_next = '0;
                state_next  = etsi_pkg::ST_SCAN;
              end
            end
            etsi_pkg::FN_DELETE: begin
              if (idx_ext < cnt_ext) begin
                rd_ptr_next = etsi_pkg::CNT_W'(in_item.index) + 1'b1;
                state_next  = etsi_pkg::ST_SHIFT;
              end
            end
            etsi_pkg::FN_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      etsi_pkg::ST_SCAN: begin
        if (issue) begin
          rd_ptr_next  = rd_ptr + 1'b1;
          rd_vld_next  = 1'b1;
          rd_addr_next = rd_ptr[etsi_pkg::IDX_W-1:0];
        end
        if (rd_vld) begin
          if (hit_pair) begin
            // The pair is stored: a query hits, an add is rejected.
            found_next = op == etsi_pkg::FN_QUERY;
            state_next = etsi_pkg::ST_DONE;
          end else if (op == etsi_pkg::FN_ADD && rd_data.na == na) begin
            first_seen_next = 1'b1;
            if (rd_data.len > len) begin
              wr_en      = 1'b1;
              wr_addr    = rd_addr;
              acc_next   = 1'b1;
              state_next = etsi_pkg::ST_DONE;
            end
          end
        end else if (!issue) begin
          state_next = etsi_pkg::ST_DONE;
          if (op == etsi_pkg::FN_ADD && !first_seen) begin
            if (tbl_full) begin
              full_next = 1'b1;
            end else begin
              wr_en      = 1'b1;
              count_next = count + 1'b1;
              acc_next   = 1'b1;
            end
          end
        end
      end

      etsi_pkg::ST_SHIFT: begin
        if (issue) begin
          rd_ptr_next  = rd_ptr + 1'b1;
          rd_vld_next  = 1'b1;
          rd_addr_next = rd_ptr[etsi_pkg::IDX_W-1:0];
        end
        if (rd_vld) begin
          // Each entry moves down by one; the read runs one entry ahead.
          wr_en   = 1'b1;
          wr_addr = rd_addr - 1'b1;
          wr_data = rd_data;
        end else if (!issue) begin
          count_next = count - 1'b1;
          acc_next   = 1'b1;
          state_next = etsi_pkg::ST_DONE;
        end
      end

      etsi_pkg::ST_DONE: begin
        if (res_ready) begin
          state_next = etsi_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = etsi_pkg::ST_IDLE;
      end
    endcase
  end

  `ETSI_ASSERT(a_count_max, clk, rst, count <= etsi_pkg::FULL_CNT)
  `ETSI_ASSERT_IMPL(a_rd_range, clk, rst, rd_vld, etsi_pkg::CNT_W'(rd_addr) < count)
  `ETSI_ASSERT_IMPL(a_wr_range, clk, rst, wr_en, etsi_pkg::CNT_W'(wr_addr) <= count)
  `ETSI_ASSERT_IMPL(a_flags, clk, rst, res_valid, !(acc && full) && !(acc && found))

endmodule

@@ bench/edge_table_shortest_insert_top_tb.sv @@
`timescale 1ns / 1ps

module edge_table_shortest_insert_top_tb;

  // Codes that select no operation.
  localparam logic [etsi_pkg::FUNC_W-1:0] FN_NOP_LO = 3'd5;
  localparam logic [etsi_pkg::FUNC_W-1:0] FN_NOP_HI = 3'd7;

  localparam int ITEMS_PER_PHASE = 190;
  localparam int STALL_LIMIT     = 20000;
  localparam int TAIL_CYCLES     = etsi_pkg::TABLE_DEPTH + 16;

  typedef struct {
    logic [etsi_pkg::FUNC_W-1:0]  func;
    logic [etsi_pkg::NODE_W-1:0]  node_a;
    logic [etsi_pkg::NODE_W-1:0]  node_b;
    logic [etsi_pkg::LEN_W-1:0]   edge_len;
    logic [etsi_pkg::INDEX_W-1:0] index;
    bit                           fixed;
    etsi_pkg::res_t               want;
  } dir_row_t;

  typedef struct packed {
    bit             fixed;
    etsi_pkg::res_t want;
  } override_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic [etsi_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tready;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [etsi_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  // Shadow copy of the edge table, advanced once per accepted input beat.
  etsi_pkg::entry_t shadow_edges [etsi_pkg::TABLE_DEPTH];
  int               shadow_count = 0;

  override_t      override_q [$];
  etsi_pkg::res_t pending_results [$];
  dir_row_t       dir_rows [$];

  int errors = 0;
  int n_sent = 0;
  int n_done = 0;
  int src_idle_pct = 0;
  int dst_stall_pct = 0;
  int quiet_cycles = 0;

  edge_table_shortest_insert_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic bit same_pair(etsi_pkg::entry_t e, logic [etsi_pkg::NODE_BITS-1:0] a,
                                   logic [etsi_pkg::NODE_BITS-1:0] b);
    return (e.na == a && e.nb == b) || (e.na == b && e.nb == a);
  endfunction

  function automatic bit push_shadow_edge(logic [etsi_pkg::NODE_BITS-1:0] a,
                                          logic [etsi_pkg::NODE_BITS-1:0] b,
                                          logic [etsi_pkg::LEN_W-1:0] len, ref bit full);
    if (shadow_count >= etsi_pkg::TABLE_DEPTH) begin
      full = 1'b1;
      return 1'b0;
    end
    shadow_edges[shadow_count] = '{len: len, nb: b, na: a};
    shadow_count++;
    return 1'b1;
  endfunction

  function automatic etsi_pkg::res_t apply_edge_op(etsi_pkg::item_t it);
    etsi_pkg::res_t                 r;
    logic [etsi_pkg::NODE_BITS-1:0] a;
    logic [etsi_pkg::NODE_BITS-1:0] b;
    logic [etsi_pkg::LEN_W-1:0]     len;
    int                             idx;
    bit                             first_seen;
    bit                             scan_done;
    bit                             acc;
    bit                             fnd;
    bit                             full;
    a = it.node_a[etsi_pkg::NODE_BITS-1:0];
    b = it.node_b[etsi_pkg::NODE_BITS-1:0];
    len = it.edge_len;
    idx = int'(it.index);
    first_seen = 1'b0;
    scan_done = 1'b0;
    acc = 1'b0;
    fnd = 1'b0;
    full = 1'b0;
    case (it.func)
      etsi_pkg::FN_ADD: begin
        if (shadow_count == 0) begin
          acc = push_shadow_edge(a, b, len, full);
        end else begin
          for (int i = idx; i < shadow_count && !scan_done; i++) begin
            if (same_pair(shadow_edges[i], a, b)) begin
              scan_done = 1'b1;
            end else if (shadow_edges[i].na == a) begin
              first_seen = 1'b1;
              if (shadow_edges[i].len > len) begin
                shadow_edges[i] = '{len: len, nb: b, na: a};
                acc = 1'b1;
                scan_done = 1'b1;
              end
            end
          end
          if (!scan_done && !first_seen) acc = push_shadow_edge(a, b, len, full);
        end
      end
      etsi_pkg::FN_QUERY: begin
        if (a == b) begin
          fnd = 1'b1;
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            if (same_pair(shadow_edges[i], a, b)) fnd = 1'b1;
          end
        end
      end
      etsi_pkg::FN_DELETE: begin
        if (idx < shadow_count) begin
          for (int i = idx; i + 1 < shadow_count; i++) shadow_edges[i] = shadow_edges[i + 1];
          shadow_count--;
          acc = 1'b1;
        end
      end
      etsi_pkg::FN_APPEND: begin
        acc = push_shadow_edge(a, b, len, full);
      end
      etsi_pkg::FN_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    r.accepted = acc;
    r.found = fnd;
    r.full_res = full;
    r.count = etsi_pkg::COUNT_W'(shadow_count);
    return r;
  endfunction

  // Small node and length pools make repeated pairs, shared first nodes and
  // replacements common; the rest of the range is still hit now and then.
  function automatic etsi_pkg::item_t random_edge_op();
    etsi_pkg::item_t it;
    logic [95:0]     raw;
    int unsigned     r;
    int unsigned     sel;
    it = '0;
    r = $urandom_range(99);
    if (r >= 97) begin
      raw = {$urandom, $urandom, $urandom};
      it = raw[$bits(etsi_pkg::item_t)-1:0];
      return it;
    end
    if (r < 38) it.func = etsi_pkg::FN_ADD;
    else if (r < 58) it.func = etsi_pkg::FN_QUERY;
    else if (r < 72) it.func = etsi_pkg::FN_DELETE;
    else if (r < 90) it.func = etsi_pkg::FN_APPEND;
    else if (r < 93) it.func = etsi_pkg::FN_CLEAR;
    else it.func = etsi_pkg::FUNC_W'($urandom_range(FN_NOP_LO, FN_NOP_HI));
    it.node_a = ($urandom_range(3) != 0) ? etsi_pkg::NODE_W'($urandom_range(7))
                                         : etsi_pkg::NODE_W'($urandom);
    it.node_b = ($urandom_range(3) != 0) ? etsi_pkg::NODE_W'($urandom_range(7))
                                         : etsi_pkg::NODE_W'($urandom);
    sel = $urandom_range(9);
    if (sel < 6) it.edge_len = etsi_pkg::LEN_W'($urandom_range(8));
    else if (sel < 9) it.edge_len = $urandom;
    else it.edge_len = $urandom_range(1) ? '1 : '0;
    sel = $urandom_range(99);
    if (it.func == etsi_pkg::FN_ADD) begin
      if (sel < 60) it.index = '0;
      else if (sel < 85) it.index = etsi_pkg::INDEX_W'($urandom_range(shadow_count));
      else it.index = etsi_pkg::INDEX_W'($urandom);
    end else if (it.func == etsi_pkg::FN_DELETE && sel < 70) begin
      it.index = etsi_pkg::INDEX_W'($urandom_range(shadow_count));
    end else begin
      it.index = etsi_pkg::INDEX_W'($urandom);
    end
    return it;
  endfunction

  task automatic send_beat(input etsi_pkg::item_t it, input bit fixed,
                           input etsi_pkg::res_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    override_q.push_back('{fixed: fixed, want: want});
    n_sent++;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= etsi_pkg::IN_TDATA_W'(it);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (n_done != n_sent) @(posedge clk);
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= dst_stall_pct);
  end

  always @(posedge clk) begin
    override_t      ov;
    etsi_pkg::res_t pred;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      ov = override_q.pop_front();
      pred = apply_edge_op(etsi_pkg::item_t'(s_axis_tdata[$bits(etsi_pkg::item_t)-1:0]));
      pending_results.push_back(ov.fixed ? ov.want : pred);
    end
  end

  always @(posedge clk) begin
    etsi_pkg::res_t got;
    etsi_pkg::res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = etsi_pkg::res_t'(m_axis_tdata[$bits(etsi_pkg::res_t)-1:0]);
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat %0d arrived with nothing expected", n_done));
      end else begin
        want = pending_results.pop_front();
        if (got.accepted !== want.accepted)
          report_mismatch($sformatf("beat %0d accepted %0b, expected %0b",
                                    n_done, got.accepted, want.accepted));
        if (got.found !== want.found)
          report_mismatch($sformatf("beat %0d found %0b, expected %0b",
                                    n_done, got.found, want.found));
        if (got.full_res !== want.full_res)
          report_mismatch($sformatf("beat %0d full_res %0b, expected %0b",
                                    n_done, got.full_res, want.full_res));
        if (got.count !== want.count)
          report_mismatch($sformatf("beat %0d count %0d, expected %0d",
                                    n_done, got.count, want.count));
      end
      n_done++;
    end
  end

  // Watchdog on cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    etsi_pkg::item_t it;
    etsi_pkg::res_t  no_fixed;
    no_fixed = '0;

    // Fixed expectations only where the answer is obvious: empty table, the first
    // add, clear and the unused codes.
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_QUERY, 16'h0005, 16'h0005, 32'h0, 12'h000,
                                  1'b1, etsi_pkg::res_t'{13'd0, 1'b0, 1'b1, 1'b0}});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_QUERY, 16'h0001, 16'h0002, 32'h0, 12'h000,
                                  1'b1, etsi_pkg::res_t'{13'd0, 1'b0, 1'b0, 1'b0}});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_DELETE, 16'h0000, 16'h0000, 32'h0, 12'h000,
                                  1'b1, etsi_pkg::res_t'{13'd0, 1'b0, 1'b0, 1'b0}});
    dir_rows.push_back(dir_row_t'{FN_NOP_LO, 16'h0001, 16'h0002, 32'h3, 12'h000,
                                  1'b1, etsi_pkg::res_t'{13'd0, 1'b0, 1'b0, 1'b0}});
    dir_rows.push_back(dir_row_t'{FN_NOP_HI, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 12'hFFF,
                                  1'b1, etsi_pkg::res_t'{13'd0, 1'b0, 1'b0, 1'b0}});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_ADD, 16'hFFFF, 16'h0000, 32'hFFFFFFFF, 12'hFFF,
                                  1'b1, etsi_pkg::res_t'{13'd1, 1'b0, 1'b0, 1'b1}});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_ADD, 16'hFFFF, 16'h0003, 32'h00010000, 12'h000,
                                  1'b0, no_fixed});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_ADD, 16'hFFFF, 16'h0003, 32'h0, 12'h000,
                                  1'b0, no_fixed});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_ADD, 16'h0003, 16'hFFFF, 32'h0, 12'h000,
                                  1'b0, no_fixed});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_ADD, 16'hFFFF, 16'h0007, 32'h00010000, 12'h000,
                                  1'b0, no_fixed});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_ADD, 16'h0002, 16'h0009, 32'h0, 12'h000,
                                  1'b0, no_fixed});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_ADD, 16'hFFFF, 16'h0008, 32'h5, 12'h001,
                                  1'b0, no_fixed});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_ADD, 16'h0004, 16'h0004, 32'h1, 12'hFFF,
                                  1'b0, no_fixed});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_APPEND, 16'h0000, 16'hFFFF, 32'hFFFFFFFF,
                                  12'h000, 1'b0, no_fixed});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_QUERY, 16'h0003, 16'hFFFF, 32'h0, 12'h000,
                                  1'b0, no_fixed});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_QUERY, 16'hFFFF, 16'h0000, 32'h0, 12'h000,
                                  1'b0, no_fixed});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_DELETE, 16'h0000, 16'h0000, 32'h0, 12'hFFF,
                                  1'b0, no_fixed});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_DELETE, 16'h0000, 16'h0000, 32'h0, 12'h001,
                                  1'b0, no_fixed});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_QUERY, 16'h0002, 16'h0009, 32'h0, 12'h000,
                                  1'b0, no_fixed});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_DELETE, 16'h0000, 16'h0000, 32'h0, 12'h003,
                                  1'b0, no_fixed});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_CLEAR, 16'h0000, 16'h0000, 32'h0, 12'h000,
                                  1'b1, etsi_pkg::res_t'{13'd0, 1'b0, 1'b0, 1'b0}});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_APPEND, 16'h5555, 16'hAAAA, 32'hAAAA5555,
                                  12'hAAA, 1'b0, no_fixed});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_ADD, 16'hAAAA, 16'h5555, 32'h5555AAAA,
                                  12'h555, 1'b0, no_fixed});
    dir_rows.push_back(dir_row_t'{etsi_pkg::FN_CLEAR, 16'h1234, 16'h4321, 32'h0, 12'h000,
                                  1'b1, etsi_pkg::res_t'{13'd0, 1'b0, 1'b0, 1'b0}});

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      it.func = dir_rows[i].func;
      it.node_a = dir_rows[i].node_a;
      it.node_b = dir_rows[i].node_b;
      it.edge_len = dir_rows[i].edge_len;
      it.index = dir_rows[i].index;
      send_beat(it, dir_rows[i].fixed, dir_rows[i].want);
    end
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = (ph == 1) ? 48 : (ph == 3) ? 29 : 0;
      dst_stall_pct = (ph == 2) ? 48 : (ph == 3) ? 29 : 0;
      if (ph == 1) begin
        // Append past the table's depth so appends, from either path, get refused.
        it = '0;
        it.func = etsi_pkg::FN_CLEAR;
        send_beat(it, 1'b0, no_fixed);
        repeat (etsi_pkg::TABLE_DEPTH + 2) begin
          it.func = etsi_pkg::FN_APPEND;
          it.node_a = etsi_pkg::NODE_W'($urandom);
          it.node_b = etsi_pkg::NODE_W'($urandom);
          it.edge_len = $urandom;
          it.index = etsi_pkg::INDEX_W'($urandom);
          send_beat(it, 1'b0, no_fixed);
        end
        repeat (3) begin
          it.func = etsi_pkg::FN_ADD;
          it.node_a = etsi_pkg::NODE_W'($urandom);
          it.index = '0;
          send_beat(it, 1'b0, no_fixed);
        end
      end
      repeat (ITEMS_PER_PHASE) send_beat(random_edge_op(), 1'b0, no_fixed);
      // Let every outstanding result come back before the next phase starts.
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
